/* rtl/pmlb_pkg.sv */
// ----------------------------------------------------------------------------
// pmlb_pkg
// shared types and constants of the peak meter led bar core
// ----------------------------------------------------------------------------
package pmlb_pkg;

    localparam int MAX_LEDS    = 64;
    localparam int LED_W       = $clog2(MAX_LEDS);
    localparam int COUNT_W     = 7;
    localparam int FADE_W      = 14;
    localparam int SAMPLE_W    = 16;
    localparam int GAIN_W      = 8;
    localparam int RAMP_W      = 16;
    localparam int LEVEL_W     = 14;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 14;
    localparam int SCALE_SHIFT = 18;

    localparam logic [COUNT_W-1:0] NUM_LEDS_RESET  = 7'd64;
    localparam logic [FADE_W-1:0]  FADE_STEP_RESET = 14'd64;
    localparam logic [LEVEL_W-1:0] LEVEL_FLOOR     = 14'd256;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_LEDS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_STEP = 2'd1;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_RENDER = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_LEVEL,
        ST_TOP,
        ST_DIV,
        ST_EMIT
    } t_state;

endpackage

/* rtl/pmlb_ifs.sv */
// ----------------------------------------------------------------------------
// pmlb channel interfaces
// input item, result item and register write channels
// ----------------------------------------------------------------------------
interface pmlb_in_if import pmlb_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       block_start;
    logic [GAIN_W-1:0]          gain;

    modport source (output valid, func, sample, block_start, gain, input ready);
    modport sink   (input valid, func, sample, block_start, gain, output ready);
endinterface

interface pmlb_out_if import pmlb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [LED_W-1:0]  led_index;
    logic              lit;
    logic [RAMP_W-1:0] ramp_value;
    logic              last;

    modport source (output valid, led_index, lit, ramp_value, last, input ready);
    modport sink   (input valid, led_index, lit, ramp_value, last, output ready);
endinterface

interface pmlb_cfg_if import pmlb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/peak_meter_led_bar_core.sv */
// ----------------------------------------------------------------------------
// peak_meter_led_bar_core
// peak hold meter with decaying bar level, one beat per led on render
// ----------------------------------------------------------------------------
// channel  dir  beat
// i_in     in   func, sample, block_start, gain
// o_out    out  led_index, lit, ramp_value, last
// i_cfg    in   index, data (0 num_leds, 1 fade_step)
//
// a sample beat updates the held peak and leaves the core idle
// a render beat runs setup (two multiplies, level, top, then 16 steps of
// the shared compare-subtract for 65535/top), then one beat per led, for
// num_leds clamped to 2..64 leds; the same compare-subtract steps the ramp
// i_in.ready is low from a render beat until the last led beat is taken
// synchronous active-low reset restores registers, peak and level to reset
// ----------------------------------------------------------------------------
module peak_meter_led_bar_core import pmlb_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pmlb_in_if.sink       i_in,
    pmlb_cfg_if.sink      i_cfg,
    pmlb_out_if.source    o_out
);

    t_state                r_state, n_state;
    logic [COUNT_W-1:0]    r_num_leds;
    logic [FADE_W-1:0]     r_fade;
    logic [SAMPLE_W-1:0]   r_peak, n_peak;
    logic [LEVEL_W-1:0]    r_bar, n_bar;
    logic [23:0]           r_prod, n_prod;
    logic [LED_W-1:0]      r_scaled, n_scaled;
    logic [LED_W-1:0]      r_top, n_top;
    logic [RAMP_W-1:0]     r_quo, n_quo;
    logic [LED_W-1:0]      r_rem, n_rem;
    logic [3:0]            r_cnt, n_cnt;
    logic [LED_W-1:0]      r_led, n_led;
    logic [RAMP_W-1:0]     r_acc_q, n_acc_q;
    logic [LED_W-1:0]      r_acc_r, n_acc_r;

    logic [COUNT_W-1:0]    led_n;
    logic [LED_W-1:0]      max_idx;
    logic                  in_beat, out_beat, cfg_beat;
    logic [SAMPLE_W-1:0]   mag;
    logic [30:0]           prod_n;
    logic [12:0]           scaled_raw;
    logic signed [15:0]    lvl;
    logic [LEVEL_W-1:0]    lvl_floor, lvl_cap, cap_val, scaled_lvl;
    logic [14:0]           top_sum;
    logic [COUNT_W-1:0]    top_raw;
    logic [COUNT_W-1:0]    cs_x, cs_diff;
    logic                  cs_ge;

    always_comb begin
        if (r_num_leds < 7'd2) begin
            led_n = 7'd2;
        end else if (r_num_leds > COUNT_W'(MAX_LEDS)) begin
            led_n = COUNT_W'(MAX_LEDS);
        end else begin
            led_n = r_num_leds;
        end
    end
    assign max_idx = LED_W'(led_n - 7'd1);

    assign in_beat  = i_in.valid & i_in.ready;
    assign out_beat = o_out.valid & o_out.ready;
    assign cfg_beat = i_cfg.valid & i_cfg.ready;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    assign mag = i_in.sample[SAMPLE_W-1] ? (~i_in.sample + 16'd1) : i_in.sample;

    // gain scaling
    assign prod_n     = 31'(r_prod) * 31'(led_n);
    assign scaled_raw = prod_n[30:SCALE_SHIFT];

    // fade, floor, cap, jump up
    assign lvl        = $signed({2'b00, r_bar}) - $signed({2'b00, r_fade});
    assign lvl_floor  = (lvl < 16'sd256) ? LEVEL_FLOOR : lvl[LEVEL_W-1:0];
    assign cap_val    = {max_idx, 8'h00};
    assign lvl_cap    = (lvl_floor > cap_val) ? cap_val : lvl_floor;
    assign scaled_lvl = {r_scaled, 8'h00};

    // round half up to an led index
    assign top_sum = {1'b0, r_bar} + 15'd128;
    assign top_raw = top_sum[14:8];

    // shared compare-subtract: divide step, then ramp step
    assign cs_x    = (r_state == ST_DIV) ? {r_rem, 1'b1}
                                         : ({1'b0, r_acc_r} + {1'b0, r_rem});
    assign cs_ge   = (cs_x >= {1'b0, r_top});
    assign cs_diff = cs_x - {1'b0, r_top};

    always_comb begin
        n_state  = r_state;
        n_peak   = r_peak;
        n_bar    = r_bar;
        n_prod   = r_prod;
        n_scaled = r_scaled;
        n_top    = r_top;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_led    = r_led;
        n_acc_q  = r_acc_q;
        n_acc_r  = r_acc_r;
        unique case (r_state)
            ST_IDLE: begin
                n_prod = 24'(r_peak) * 24'(i_in.gain);
                if (in_beat) begin
                    if (i_in.func == FUNC_SAMPLE) begin
                        if (i_in.block_start || (mag > r_peak)) begin
                            n_peak = mag;
                        end
                    end else begin
                        n_state = ST_SCALE;
                    end
                end
            end
            ST_SCALE: begin
                if (scaled_raw > 13'(max_idx)) begin
                    n_scaled = max_idx;
                end else if (scaled_raw < 13'd1) begin
                    n_scaled = LED_W'(1);
                end else begin
                    n_scaled = scaled_raw[LED_W-1:0];
                end
                n_state = ST_LEVEL;
            end
            ST_LEVEL: begin
                n_bar   = (scaled_lvl > lvl_cap) ? scaled_lvl : lvl_cap;
                n_state = ST_TOP;
            end
            ST_TOP: begin
                if (top_raw < 7'd1) begin
                    n_top = LED_W'(1);
                end else if (top_raw > {1'b0, max_idx}) begin
                    n_top = max_idx;
                end else begin
                    n_top = top_raw[LED_W-1:0];
                end
                n_rem   = '0;
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_rem = cs_ge ? cs_diff[LED_W-1:0] : cs_x[LED_W-1:0];
                n_quo = {r_quo[RAMP_W-2:0], cs_ge};
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    n_led   = '0;
                    n_acc_q = '0;
                    n_acc_r = '0;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_beat) begin
                    n_acc_q = r_acc_q + r_quo + RAMP_W'(cs_ge);
                    n_acc_r = cs_ge ? cs_diff[LED_W-1:0] : cs_x[LED_W-1:0];
                    n_led   = r_led + LED_W'(1);
                    if (r_led == max_idx) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_num_leds <= NUM_LEDS_RESET;
            r_fade     <= FADE_STEP_RESET;
            r_peak     <= '0;
            r_bar      <= '0;
        end else begin
            r_state <= n_state;
            r_peak  <= n_peak;
            r_bar   <= n_bar;
            if (cfg_beat) begin
                unique case (i_cfg.index)
                    CFG_NUM_LEDS:  r_num_leds <= i_cfg.data[COUNT_W-1:0];
                    CFG_FADE_STEP: r_fade     <= i_cfg.data[FADE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= n_prod;
        r_scaled <= n_scaled;
        r_top    <= n_top;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_led    <= n_led;
        r_acc_q  <= n_acc_q;
        r_acc_r  <= n_acc_r;
    end

    assign o_out.valid      = (r_state == ST_EMIT);
    assign o_out.led_index  = r_led;
    assign o_out.lit        = (r_led <= r_top);
    assign o_out.ramp_value = (r_led <= r_top) ? r_acc_q : '0;
    assign o_out.last       = (r_led == max_idx);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while a led beat is pending");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_beat && o_out.last) |=> i_in.ready)
        else $error("not ready after the last led beat");

    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_top >= LED_W'(1)) && (r_top <= max_idx))
        else $error("bar top out of range");

    a_full_ramp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (r_led == r_top)) |-> (o_out.ramp_value == 16'hFFFF))
        else $error("ramp at bar top is not full scale");

    a_level_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LEVEL) |=> (r_bar >= LEVEL_FLOOR))
        else $error("bar level below floor after render");

endmodule

/* verif/peak_meter_led_bar_core_tb.sv */
// ----------------------------------------------------------------------------
// peak_meter_led_bar_core_tb
// drives sample and render beats into the peak meter core, predicts every led
// beat of each rendered frame from its own copy of peak, level and registers,
// and checks the led beats in order under several sender and receiver idling
// patterns and register settings
// ----------------------------------------------------------------------------
module peak_meter_led_bar_core_tb import pmlb_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [LED_W-1:0]  led_index;
        logic              lit;
        logic [RAMP_W-1:0] ramp_value;
        logic              last;
    } t_led_beat;

    logic i_clk;
    logic i_rst_n;

    pmlb_in_if  in_ch ();
    pmlb_out_if out_ch ();
    pmlb_cfg_if cfg_ch ();

    peak_meter_led_bar_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    logic [COUNT_W-1:0]  leds_reg   = NUM_LEDS_RESET;
    logic [FADE_W-1:0]   fade_reg   = FADE_STEP_RESET;
    logic [SAMPLE_W-1:0] peak_hold  = '0;
    logic [LEVEL_W-1:0]  level_hold = '0;

    t_led_beat led_beats_due [$];
    int mismatches    = 0;
    int cycles        = 0;
    int in_gap_pct    = 0;
    int out_stall_pct = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("peak_meter_led_bar_core_tb NOT OK");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
    end

    function automatic void track_peak(input logic signed [SAMPLE_W-1:0] smp, input logic bs);
        int mag;
        mag = (smp < 0) ? -int'(smp) : int'(smp);
        if (bs || mag > int'(peak_hold))
            peak_hold = SAMPLE_W'(mag);
    endfunction

    function automatic void predict_frame(input logic [GAIN_W-1:0] g);
        int n;
        int max_idx;
        int scaled;
        int lvl;
        int top;
        t_led_beat b;
        n = (leds_reg < 2) ? 2 : (leds_reg > MAX_LEDS) ? MAX_LEDS : int'(leds_reg);
        max_idx = n - 1;
        scaled = int'((longint'(peak_hold) * longint'(g) * longint'(n)) >> SCALE_SHIFT);
        if (scaled > max_idx) scaled = max_idx;
        if (scaled < 1) scaled = 1;
        lvl = int'(level_hold) - int'(fade_reg);
        if (lvl < int'(LEVEL_FLOOR)) lvl = int'(LEVEL_FLOOR);
        if (lvl > max_idx * 256) lvl = max_idx * 256;
        if (scaled * 256 > lvl) lvl = scaled * 256;
        level_hold = LEVEL_W'(lvl);
        top = (int'(level_hold) + 128) >> 8;
        if (top < 1) top = 1;
        if (top > max_idx) top = max_idx;
        for (int i = 0; i < n; i++) begin
            b.led_index  = LED_W'(i);
            b.lit        = (i <= top);
            b.ramp_value = b.lit ? RAMP_W'((i * 65535) / top) : '0;
            b.last       = (i == max_idx);
            led_beats_due.push_back(b);
        end
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_led_beat want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (led_beats_due.size() == 0) begin
                mismatches++;
                $display("%0t: led beat expected none, got led_index %0d",
                         $time, out_ch.led_index);
            end else begin
                want = led_beats_due.pop_front();
                check_field("led_index", want.led_index, out_ch.led_index);
                check_field("lit", want.lit, out_ch.lit);
                check_field("ramp_value", want.ramp_value, out_ch.ramp_value);
                check_field("last", want.last, out_ch.last);
            end
        end
    end

    // called and returns at a falling edge; valid stays up for a following beat
    task automatic send_beat(input logic func, input logic signed [SAMPLE_W-1:0] smp,
                             input logic bs, input logic [GAIN_W-1:0] g);
        while ($urandom_range(99) < in_gap_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.func        <= func;
        in_ch.sample      <= smp;
        in_ch.block_start <= bs;
        in_ch.gain        <= g;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (func == FUNC_SAMPLE)
            track_peak(smp, bs);
        else
            predict_frame(g);
        @(negedge i_clk);
    endtask

    task automatic drain(input int extra);
        in_ch.valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (led_beats_due.size() != 0);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic set_regs(input logic [CFG_DATA_W-1:0] leds_data,
                            input logic [CFG_DATA_W-1:0] fade_data, input bit poke_spare);
        logic [CFG_IDX_W-1:0]  idx [4];
        logic [CFG_DATA_W-1:0] val [4];
        idx[0] = CFG_SPARE_2;   val[0] = CFG_DATA_W'($urandom);
        idx[1] = CFG_NUM_LEDS;  val[1] = leds_data;
        idx[2] = CFG_SPARE_3;   val[2] = CFG_DATA_W'($urandom);
        idx[3] = CFG_FADE_STEP; val[3] = fade_data;
        for (int k = 0; k < 4; k++) begin
            if (poke_spare || idx[k] == CFG_NUM_LEDS || idx[k] == CFG_FADE_STEP) begin
                cfg_ch.valid <= 1'b1;
                cfg_ch.index <= idx[k];
                cfg_ch.data  <= val[k];
                @(posedge i_clk);
                while (!cfg_ch.ready) @(posedge i_clk);
                case (idx[k])
                    CFG_NUM_LEDS:  leds_reg = val[k][COUNT_W-1:0];
                    CFG_FADE_STEP: fade_reg = val[k];
                    default: ;
                endcase
                @(negedge i_clk);
            end
        end
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        logic signed [SAMPLE_W-1:0] s;
        s = SAMPLE_W'($urandom);
        return s >>> $urandom_range(0, 10);
    endfunction

    task automatic test_sample_extremes();
        send_beat(FUNC_RENDER, 16'sd0, 1'b0, 8'd0);
        send_beat(FUNC_SAMPLE, -16'sd32768, 1'b1, 8'd0);
        send_beat(FUNC_SAMPLE, 16'sd32767, 1'b0, 8'd0);
        send_beat(FUNC_RENDER, 16'sd0, 1'b0, 8'd1);
        send_beat(FUNC_SAMPLE, 16'sd0, 1'b1, 8'd255);
        send_beat(FUNC_SAMPLE, -16'sd1, 1'b0, 8'd0);
        send_beat(FUNC_SAMPLE, 16'sd1, 1'b0, 8'd0);
        send_beat(FUNC_RENDER, -16'sd1, 1'b1, 8'd255);
        send_beat(FUNC_SAMPLE, 16'sd32767, 1'b1, 8'd0);
        send_beat(FUNC_RENDER, 16'sd0, 1'b0, 8'd255);
        send_beat(FUNC_SAMPLE, -16'sd32768, 1'b0, 8'd0);
        send_beat(FUNC_RENDER, 16'sd0, 1'b0, 8'd128);
        drain(DRAIN_CYCLES);
    endtask

    task automatic test_led_count_limits();
        set_regs(14'd0, 14'd64, 1'b1);
        send_beat(FUNC_RENDER, 16'sd0, 1'b0, 8'd255);
        drain(DRAIN_CYCLES);
        set_regs(14'd1, 14'd64, 1'b1);
        send_beat(FUNC_RENDER, 16'sd0, 1'b0, 8'd255);
        drain(DRAIN_CYCLES);
        set_regs(14'h3FFF, 14'd64, 1'b0);
        send_beat(FUNC_RENDER, 16'sd0, 1'b0, 8'd255);
        drain(DRAIN_CYCLES);
        set_regs(14'd64, 14'd0, 1'b0);
        send_beat(FUNC_SAMPLE, 16'sd32767, 1'b1, 8'd0);
        send_beat(FUNC_RENDER, 16'sd0, 1'b0, 8'd255);
        drain(DRAIN_CYCLES);
        // fewer leds with a high held level
        set_regs(14'h3F88, 14'd0, 1'b1);
        send_beat(FUNC_RENDER, 16'sd0, 1'b0, 8'd0);
        drain(DRAIN_CYCLES);
    endtask

    task automatic test_fade_limits();
        set_regs(14'd64, 14'd16383, 1'b0);
        send_beat(FUNC_RENDER, 16'sd0, 1'b0, 8'd0);
        drain(DRAIN_CYCLES);
        set_regs(14'd16, 14'd1, 1'b0);
        send_beat(FUNC_SAMPLE, 16'sd12000, 1'b1, 8'd0);
        send_beat(FUNC_RENDER, 16'sd0, 1'b0, 8'd200);
        send_beat(FUNC_SAMPLE, 16'sd100, 1'b1, 8'd0);
        send_beat(FUNC_RENDER, 16'sd0, 1'b0, 8'd200);
        send_beat(FUNC_RENDER, 16'sd0, 1'b0, 8'd200);
        drain(DRAIN_CYCLES);
    endtask

    task automatic test_random_traffic(input int n_items, input int gap, input int stall,
                                       input logic [CFG_DATA_W-1:0] leds_data,
                                       input logic [CFG_DATA_W-1:0] fade_data);
        int sent;
        int burst;
        bit paused;
        sent = 0;
        paused = 1'b0;
        in_gap_pct = gap;
        out_stall_pct = stall;
        set_regs(leds_data, fade_data, 1'b1);
        while (sent < n_items) begin
            if (!paused && sent >= n_items / 2) begin
                drain(0);
                paused = 1'b1;
            end
            if ($urandom_range(99) < 80) begin
                burst = $urandom_range(0, 6);
                send_beat(FUNC_SAMPLE, rand_sample(), 1'b1, GAIN_W'($urandom));
                repeat (burst)
                    send_beat(FUNC_SAMPLE, rand_sample(), $urandom_range(0, 7) == 0,
                              GAIN_W'($urandom));
                send_beat(FUNC_RENDER, SAMPLE_W'($urandom), 1'($urandom),
                          GAIN_W'($urandom));
                sent += burst + 2;
            end else begin
                send_beat(1'($urandom), SAMPLE_W'($urandom), 1'($urandom),
                          GAIN_W'($urandom));
                sent++;
            end
        end
        drain(DRAIN_CYCLES);
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.func         <= FUNC_SAMPLE;
        in_ch.sample       <= '0;
        in_ch.block_start  <= 1'b0;
        in_ch.gain         <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= CFG_NUM_LEDS;
        cfg_ch.data        <= '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_sample_extremes();
        test_led_count_limits();
        test_fade_limits();
        test_random_traffic(100, 0, 0, 14'd2, 14'd0);
        test_random_traffic(100, 50, 0, 14'd64, 14'd16383);
        test_random_traffic(100, 0, 50, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
        test_random_traffic(100, 25, 25, CFG_DATA_W'($urandom_range(2, 64)),
                            CFG_DATA_W'($urandom_range(0, 600)));

        drain(DRAIN_CYCLES);
        if (mismatches == 0 && led_beats_due.size() == 0)
            $display("peak_meter_led_bar_core_tb OK");
        else
            $display("peak_meter_led_bar_core_tb NOT OK");
        $finish;
    end

endmodule
